### sv/gbo_pkg.sv
// gbo_pkg: shared types and constants for the breadth-first order block
// state encoding, item kinds, and the command/status bundles between
// the controller and the datapath; no dependencies
package gbo_pkg;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_EDGE  = 2'd1;
  localparam logic [1:0] KIND_RUN   = 2'd2;

  localparam logic [6:0] VERTEX_COUNT_RESET = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_B,
    ST_SCAN,
    ST_ENQ,
    ST_ROW,
    ST_FRESH
  } gbo_state_t;

  typedef struct packed {
    logic clear_adj;   // drop every adjacency row
    logic write_a;     // set bit b in row a, latch endpoints
    logic write_b;     // set bit a in row b
    logic run_init;    // clear visited, queue pointers and emit count
    logic scan;        // seed the walk with the lowest unvisited vertex
    logic enq;         // push the lowest pending neighbor
    logic pop;         // read the queue head
    logic emit;        // load output register, read adjacency row
    logic load_fresh;  // pending neighbors from the row just read
  } gbo_cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic n_zero;
    logic unv_none;
    logic fresh_none;
    logic queue_empty;
    logic out_free;
  } gbo_stat_t;

endpackage

### sv/gbo_ctrl.sv
// gbo_ctrl: sequencer for item handling and the breadth-first walk
// depends on gbo_pkg; drives gbo_dp through gbo_cmd_t
module gbo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  output logic              in_ready,
  input  gbo_pkg::gbo_stat_t stat,
  output gbo_pkg::gbo_cmd_t  cmd
);

  gbo_pkg::gbo_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      gbo_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_kind)
            gbo_pkg::KIND_CLEAR: begin
              cmd.clear_adj = 1'b1;
            end
            gbo_pkg::KIND_EDGE: begin
              if (stat.edge_ok) begin
                cmd.write_a = 1'b1;
                state_next  = gbo_pkg::ST_EDGE_B;
              end
            end
            gbo_pkg::KIND_RUN: begin
              if (!stat.n_zero) begin
                cmd.run_init = 1'b1;
                state_next   = gbo_pkg::ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      gbo_pkg::ST_EDGE_B: begin
        cmd.write_b = 1'b1;
        state_next  = gbo_pkg::ST_IDLE;
      end
      gbo_pkg::ST_SCAN: begin
        if (stat.unv_none) begin
          state_next = gbo_pkg::ST_IDLE;
        end else begin
          cmd.scan   = 1'b1;
          state_next = gbo_pkg::ST_ENQ;
        end
      end
      gbo_pkg::ST_ENQ: begin
        priority if (!stat.fresh_none) begin
          cmd.enq = 1'b1;
        end else if (!stat.queue_empty) begin
          cmd.pop    = 1'b1;
          state_next = gbo_pkg::ST_ROW;
        end else begin
          state_next = gbo_pkg::ST_SCAN;
        end
      end
      gbo_pkg::ST_ROW: begin
        // wait for the output register to drain
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = gbo_pkg::ST_FRESH;
        end
      end
      gbo_pkg::ST_FRESH: begin
        cmd.load_fresh = 1'b1;
        state_next     = gbo_pkg::ST_ENQ;
      end
      default: begin
        state_next = gbo_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### sv/gbo_dp.sv
// gbo_dp: adjacency memory with row valid bits, vertex queue memory,
// visited set, pending-neighbor word and output register; depends on gbo_pkg
module gbo_dp #(
  parameter int MAX_VERTICES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  gbo_pkg::gbo_cmd_t  cmd,
  output gbo_pkg::gbo_stat_t stat,
  input  logic [6:0]         edge_end_a,
  input  logic [6:0]         edge_end_b,
  input  logic               cfg_valid,
  input  logic [6:0]         cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [6:0]         out_vertex,
  output logic               out_last
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [6:0]              vertex_count;
  logic [6:0]              n_eff;
  logic [MAX_VERTICES-1:0] active_mask;

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] adj_rd;
  logic                    rd_valid;

  logic [IW-1:0]           queue_mem [MAX_VERTICES];
  logic [CW-1:0]           head;
  logic [CW-1:0]           tail;
  logic [IW-1:0]           q_idx;
  logic [CW-1:0]           emit_cnt;

  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] fresh;
  logic [MAX_VERTICES-1:0] unvisited;
  logic [MAX_VERTICES-1:0] iso_unv;
  logic [MAX_VERTICES-1:0] iso_fresh;
  logic [IW-1:0]           enq_idx;

  logic [6:0]              edge_a_q;
  logic [6:0]              edge_b_q;
  logic                    wr_en;
  logic [IW-1:0]           wr_row;
  logic [IW-1:0]           wr_col;
  logic [MAX_VERTICES-1:0] wr_bit;
  logic [MAX_VERTICES-1:0] wr_mask;

  // vertex count above the array bound acts as the bound
  assign n_eff = (vertex_count > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vertex_count;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      active_mask[i] = (7'(i) < n_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= gbo_pkg::VERTEX_COUNT_RESET;
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  // edge write: row a from the input, then row b from latched endpoints
  assign wr_en  = cmd.write_a | cmd.write_b;
  assign wr_row = cmd.write_a ? IW'(edge_end_a - 7'd1) : IW'(edge_a_q - 7'd1);
  assign wr_col = cmd.write_a ? IW'(edge_end_b - 7'd1) : IW'(edge_b_q - 7'd1);
  assign wr_bit = MAX_VERTICES'(1) << wr_col;
  // a row not yet valid is written whole so stale bits vanish
  assign wr_mask = row_valid[wr_row] ? wr_bit : '1;

  always_ff @(posedge clk) begin
    if (cmd.write_a) begin
      edge_a_q <= edge_end_b;
      edge_b_q <= edge_end_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_adj) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        if (wr_mask[i]) begin
          adj_mem[wr_row][i] <= wr_bit[i];
        end
      end
    end
    if (cmd.emit) begin
      adj_rd   <= adj_mem[q_idx];
      rd_valid <= row_valid[q_idx];
    end
  end

  assign stat.edge_ok = (edge_end_a != 7'd0) && (edge_end_a <= n_eff) &&
                        (edge_end_b != 7'd0) && (edge_end_b <= n_eff);

  // lowest set bit of the unvisited and pending words
  assign unvisited = ~visited & active_mask;
  assign iso_unv   = unvisited & (~unvisited + MAX_VERTICES'(1));
  assign iso_fresh = fresh & (~fresh + MAX_VERTICES'(1));

  always_comb begin
    enq_idx = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (iso_fresh[i]) begin
        enq_idx = enq_idx | IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      queue_mem[tail[IW-1:0]] <= enq_idx;
    end
    if (cmd.pop) begin
      q_idx <= queue_mem[head[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.run_init) begin
      head     <= '0;
      tail     <= '0;
      emit_cnt <= '0;
      visited  <= '0;
      fresh    <= '0;
    end else begin
      if (cmd.enq) begin
        tail    <= tail + CW'(1);
        visited <= visited | iso_fresh;
        fresh   <= fresh & ~iso_fresh;
      end
      if (cmd.scan) begin
        fresh <= iso_unv;
      end
      if (cmd.load_fresh) begin
        fresh <= (rd_valid ? adj_rd : '0) & active_mask & ~visited;
      end
      if (cmd.pop) begin
        head <= head + CW'(1);
      end
      if (cmd.emit) begin
        emit_cnt <= emit_cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // every vertex in range is emitted once, so the last one closes the count
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_vertex <= 7'(q_idx) + 7'd1;
      out_last   <= ((7'(emit_cnt) + 7'd1) == n_eff);
    end
  end

  assign stat.n_zero      = (n_eff == 7'd0);
  assign stat.unv_none    = (unvisited == '0);
  assign stat.fresh_none  = (fresh == '0);
  assign stat.queue_empty = (head == tail);
  assign stat.out_free    = !out_valid || out_ready;

endmodule

### sv/graph_bfs_order.sv
// Breadth-first visiting order over an undirected graph held as an adjacency matrix.
// Clear items, ignored edge items, runs with a zero vertex count and unused kinds are taken
// in the idle state alone; an edge item that is in range writes row a, then row b (one
// adjacency row write per cycle); a clear needs no clearing pass since rows carry valid bits.
// A run emits all vertices 1..min(vertex_count, MAX_VERTICES) breadth first; each component
// start scans and enqueues its seed, each emitted vertex takes a queue read, an adjacency
// row read and a reload, and each fresh neighbor takes an enqueue; these steps run in turn
// since each memory has a single read port, and a stall on the output holds the row read.
// The next item is taken once the walk ends. depends on gbo_pkg, gbo_ctrl, gbo_dp
module graph_bfs_order #(
  parameter int MAX_VERTICES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [6:0] edge_end_a, [13:7] edge_end_b, [15:14] zero
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] vertex, [7] zero
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  gbo_pkg::gbo_cmd_t  cmd;
  gbo_pkg::gbo_stat_t stat;
  logic [6:0]         out_vertex;

  gbo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gbo_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .edge_end_a (s_tdata[6:0]),
    .edge_end_b (s_tdata[13:7]),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_vertex (out_vertex),
    .out_last   (m_tlast)
  );

  assign cfg_ready = 1'b1;
  assign m_tdata   = {1'b0, out_vertex};

endmodule

### tb/sv/tb.sv
// tb: self-checking bench for graph_bfs_order, breadth-first visiting order
// drives edge, clear and run transactions, predicts the vertex stream on its own copy of
// the adjacency matrix and compares every output transaction; depends on gbo_pkg
module tb;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 32;

  typedef struct packed {
    logic [6:0] vertex;
    logic       last;
  } visit_t;

  typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_op_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_ASCENDING, EXP_NONE} row_exp_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

  typedef struct packed {
    row_op_t    op;
    logic [1:0] kind;
    logic [6:0] a;     // endpoint a, or the vertex count on a register row
    logic [6:0] b;
    row_exp_t   want;
  } script_row_t;

  localparam int SCRIPT_LEN = 26;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [6:0] edge_end_a, [13:7] edge_end_b, [15:14] zero
  logic [1:0]  s_tuser = '0;   // [1:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [6:0] vertex, [7] zero
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  // predictor state
  logic [63:0] adj_rows [64];
  logic [6:0]  vcount = gbo_pkg::VERTEX_COUNT_RESET;
  visit_t      bfs_expected [$];

  int       fail_count = 0;
  int       cycle_count = 0;
  bit       tx_up = 1'b0;
  int       burst_left = 1;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;

  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_ITEM, gbo_pkg::KIND_RUN,   7'd0,   7'd0,   EXP_ASCENDING},
    '{ROW_ITEM, KIND_UNUSED,         7'd127, 7'd127, EXP_NONE},
    '{ROW_ITEM, gbo_pkg::KIND_EDGE,  7'd1,   7'd64,  EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_EDGE,  7'd64,  7'd64,  EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_EDGE,  7'd0,   7'd5,   EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_EDGE,  7'd65,  7'd2,   EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_EDGE,  7'd3,   7'd127, EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_EDGE,  7'd2,   7'd3,   EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_EDGE,  7'd42,  7'd21,  EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_RUN,   7'd0,   7'd0,   EXP_MODEL},
    '{ROW_CFG,  gbo_pkg::KIND_CLEAR, 7'd127, 7'd0,   EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_RUN,   7'd0,   7'd0,   EXP_MODEL},
    '{ROW_CFG,  gbo_pkg::KIND_CLEAR, 7'd10,  7'd0,   EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_EDGE,  7'd10,  7'd11,  EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_EDGE,  7'd10,  7'd1,   EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_RUN,   7'd0,   7'd0,   EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_CLEAR, 7'd0,   7'd0,   EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_RUN,   7'd0,   7'd0,   EXP_ASCENDING},
    '{ROW_CFG,  gbo_pkg::KIND_CLEAR, 7'd0,   7'd0,   EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_EDGE,  7'd1,   7'd1,   EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_RUN,   7'd0,   7'd0,   EXP_NONE},
    '{ROW_CFG,  gbo_pkg::KIND_CLEAR, 7'd1,   7'd0,   EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_EDGE,  7'd1,   7'd1,   EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_RUN,   7'd0,   7'd0,   EXP_MODEL},
    '{ROW_CFG,  gbo_pkg::KIND_CLEAR, 7'd64,  7'd0,   EXP_MODEL},
    '{ROW_ITEM, gbo_pkg::KIND_CLEAR, 7'd0,   7'd0,   EXP_MODEL}
  };

  graph_bfs_order i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int live_count();
    return (vcount > 7'd64) ? 64 : int'(vcount);
  endfunction

  // applies one accepted item to the matrix copy and queues the vertex order of a run
  task automatic predict_item(input logic [1:0] k, input logic [6:0] ea, input logic [6:0] eb);
    int          n;
    int          head;
    int          x;
    logic [63:0] seen;
    logic [63:0] fresh;
    int          order [$];
    visit_t      v;
    n = live_count();
    head = 0;
    seen = '0;
    case (k)
      gbo_pkg::KIND_CLEAR: begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
      end
      gbo_pkg::KIND_EDGE: begin
        if (ea >= 1 && ea <= n && eb >= 1 && eb <= n) begin
          adj_rows[ea - 1][eb - 1] = 1'b1;
          adj_rows[eb - 1][ea - 1] = 1'b1;
        end
      end
      gbo_pkg::KIND_RUN: begin
        for (int s = 1; s <= n; s++) begin
          if (!seen[s - 1]) begin
            seen[s - 1] = 1'b1;
            order = {order, s};
            while (head < order.size()) begin
              x = order[head];
              head++;
              fresh = adj_rows[x - 1] & ~seen;
              // vertices above the live count are never followed
              for (int y = 1; y <= n; y++) begin
                if (fresh[y - 1]) begin
                  seen[y - 1] = 1'b1;
                  order = {order, y};
                end
              end
            end
          end
        end
        foreach (order[i]) begin
          v.vertex = order[i][6:0];
          v.last = (i == order.size() - 1);
          bfs_expected = {bfs_expected, v};
        end
      end
      default: begin
      end
    endcase
  endtask

  // a run over an empty matrix visits 1..n in order
  task automatic expect_ascending();
    visit_t v;
    for (int i = 1; i <= live_count(); i++) begin
      v.vertex = i[6:0];
      v.last = (i == live_count());
      bfs_expected = {bfs_expected, v};
    end
  endtask

  task automatic drop_valid();
    if (tx_up) begin
      s_tvalid <= 1'b0;
      tx_up = 1'b0;
    end
  endtask

  task automatic send_item(input logic [1:0] k, input logic [6:0] ea, input logic [6:0] eb);
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= {2'b00, eb, ea};
    tx_up = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // waits out every pending vertex, then the tail of an edge write or a silent run
  task automatic wait_idle();
    drop_valid();
    @(posedge clk);
    while (bfs_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    vcount = value;
  endtask

  // bursts with gaps, and now and then a full drain of the output side
  task automatic pace(input bit quiet);
    int gap;
    if ($urandom_range(0, 24) == 0) begin
      drop_valid();
      @(posedge clk);
      while (bfs_expected.size() != 0) @(posedge clk);
    end else if (!quiet) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 6);
        drop_valid();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [6:0] phase_count(input int ph);
    case (ph)
      0: return 7'($urandom_range(2, 12));
      1: return 7'd64;
      2: return 7'd0;
      3: return 7'($urandom_range(65, 127));
      4: return 7'd1;
      5: return 7'($urandom_range(2, 20));
      6: return 7'($urandom_range(2, 12));
      default: return 7'($urandom_range(13, 40));
    endcase
  endfunction

  task automatic note_mismatch(input bit pending, input visit_t want, input visit_t got);
    fail_count++;
    if (fail_count <= 10) begin
      if (pending)
        $display("vertex mismatch: expected %0d last %0b, got %0d last %0b",
                 want.vertex, want.last, got.vertex, got.last);
      else
        $display("vertex %0d last %0b with nothing pending", got.vertex, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(40, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= (rx_tick % 5) < 3;
    endcase
  end

  always @(posedge clk) begin
    visit_t got;
    visit_t want;
    got.vertex = m_tdata[6:0];
    got.last = m_tlast;
    want = '0;
    if (!rst && m_tvalid && m_tready) begin
      if (bfs_expected.size() == 0) begin
        note_mismatch(1'b0, want, got);
      end else begin
        want = bfs_expected.pop_front();
        if (got !== want) note_mismatch(1'b1, want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int         pick;
    int         n;
    bit         quiet;
    logic [1:0] k;
    logic [6:0] ea;
    logic [6:0] eb;
    foreach (adj_rows[i]) adj_rows[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[r]) begin
      if (script[r].op == ROW_CFG) begin
        wait_idle();
        write_count(script[r].a);
      end else begin
        send_item(script[r].kind, script[r].a, script[r].b);
        case (script[r].want)
          EXP_ASCENDING: expect_ascending();
          EXP_NONE: begin
          end
          default: predict_item(script[r].kind, script[r].a, script[r].b);
        endcase
        pace(1'b0);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_count(phase_count(ph));
      quiet = (ph % 3 == 1);
      for (int i = 0; i <= PHASE_ITEMS; i++) begin
        n = live_count();
        pick = $urandom_range(0, 99);
        ea = 7'($urandom_range(0, 127));
        eb = 7'($urandom_range(0, 127));
        if (i == PHASE_ITEMS) begin
          k = gbo_pkg::KIND_RUN;
        end else if (pick < 68) begin
          k = gbo_pkg::KIND_EDGE;
          if (n > 0) begin
            ea = 7'($urandom_range(1, n));
            eb = 7'($urandom_range(1, n));
          end
        end else if (pick < 78) begin
          k = gbo_pkg::KIND_EDGE;
        end else if (pick < 91) begin
          k = gbo_pkg::KIND_RUN;
        end else if (pick < 95) begin
          k = gbo_pkg::KIND_CLEAR;
        end else begin
          k = KIND_UNUSED;
        end
        send_item(k, ea, eb);
        predict_item(k, ea, eb);
        pace(quiet);
      end
    end

    drop_valid();
    @(posedge clk);
    while (bfs_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
sv/gbo_pkg.sv
sv/gbo_ctrl.sv
sv/gbo_dp.sv
sv/graph_bfs_order.sv
tb/sv/tb.sv
